[src/box_intersection_over_union_unit_defines.svh]
// Assertion macros shared by the box intersection over union unit.
`ifndef BOX_INTERSECTION_OVER_UNION_UNIT_DEFINES_SVH
`define BOX_INTERSECTION_OVER_UNION_UNIT_DEFINES_SVH

// Checks that a condition implies a property in the same cycle.
`define BIOIU_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("same-cycle implication failed");

// Checks that a condition implies a property in the following cycle.
`define BIOIU_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle implication failed");

`endif

[src/bioiu_pkg.sv]
// Package with field widths and payload types of the box intersection over union unit.
`timescale 1ns / 1ps
`default_nettype none

package bioiu_pkg;

    localparam int COORD_BITS = 13;
    localparam int FRAC_BITS  = 16;
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int RATIO_BITS = FRAC_BITS + 1;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int UNION_BITS = 2 * COORD_BITS + 1;

    localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRAC_BITS;

    typedef struct packed {
        logic [COORD_BITS-1:0] a_left;
        logic [COORD_BITS-1:0] a_top;
        logic [COORD_BITS-1:0] a_width;
        logic [COORD_BITS-1:0] a_height;
        logic [COORD_BITS-1:0] b_left;
        logic [COORD_BITS-1:0] b_top;
        logic [COORD_BITS-1:0] b_width;
        logic [COORD_BITS-1:0] b_height;
    } box_pair_t;

    typedef struct packed {
        logic [RATIO_BITS-1:0] overlap_ratio;
        logic [AREA_BITS-1:0]  overlap_area;
        logic [UNION_BITS-1:0] union_size;
    } iou_result_t;

    typedef struct packed {
        logic                  hit;
        logic [AREA_BITS-1:0]  overlap_area;
        logic [UNION_BITS-1:0] union_size;
    } geom_item_t;

endpackage

`default_nettype wire

[src/bioiu_geom.sv]
// Four-stage geometry pipeline that forms the overlap area and the union area.
`timescale 1ns / 1ps
`default_nettype none

module bioiu_geom
    import bioiu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  box_pair_t  in_box,
    output logic       out_valid,
    output geom_item_t out_item
);

    logic                  s1_valid_reg, s1_valid_next;
    logic [AREA_BITS-1:0]  s1_area_a_reg, s1_area_a_next;
    logic [AREA_BITS-1:0]  s1_area_b_reg, s1_area_b_next;
    logic [EDGE_BITS-1:0]  s1_x0_reg, s1_x0_next;
    logic [EDGE_BITS-1:0]  s1_y0_reg, s1_y0_next;
    logic [EDGE_BITS-1:0]  s1_x1_reg, s1_x1_next;
    logic [EDGE_BITS-1:0]  s1_y1_reg, s1_y1_next;

    logic                  s2_valid_reg, s2_valid_next;
    logic                  s2_hit_reg, s2_hit_next;
    logic [COORD_BITS-1:0] s2_dx_reg, s2_dx_next;
    logic [COORD_BITS-1:0] s2_dy_reg, s2_dy_next;
    logic [AREA_BITS-1:0]  s2_area_a_reg, s2_area_a_next;
    logic [AREA_BITS-1:0]  s2_area_b_reg, s2_area_b_next;

    logic                  s3_valid_reg, s3_valid_next;
    logic                  s3_hit_reg, s3_hit_next;
    logic [AREA_BITS-1:0]  s3_ovl_reg, s3_ovl_next;
    logic [UNION_BITS-1:0] s3_sum_reg, s3_sum_next;

    logic                  s4_valid_reg, s4_valid_next;
    geom_item_t            s4_item_reg, s4_item_next;

    logic [EDGE_BITS-1:0]  a_right, a_bottom, b_right, b_bottom;

    always_comb
    begin
        a_right  = EDGE_BITS'(in_box.a_left) + EDGE_BITS'(in_box.a_width);
        a_bottom = EDGE_BITS'(in_box.a_top) + EDGE_BITS'(in_box.a_height);
        b_right  = EDGE_BITS'(in_box.b_left) + EDGE_BITS'(in_box.b_width);
        b_bottom = EDGE_BITS'(in_box.b_top) + EDGE_BITS'(in_box.b_height);

        s1_valid_next  = in_valid;
        s1_area_a_next = AREA_BITS'(in_box.a_width) * AREA_BITS'(in_box.a_height);
        s1_area_b_next = AREA_BITS'(in_box.b_width) * AREA_BITS'(in_box.b_height);
        s1_x0_next     = EDGE_BITS'((in_box.a_left > in_box.b_left) ? in_box.a_left
                                                                    : in_box.b_left);
        s1_y0_next     = EDGE_BITS'((in_box.a_top > in_box.b_top) ? in_box.a_top
                                                                  : in_box.b_top);
        s1_x1_next     = (a_right < b_right) ? a_right : b_right;
        s1_y1_next     = (a_bottom < b_bottom) ? a_bottom : b_bottom;
    end

    always_comb
    begin
        s2_valid_next  = s1_valid_reg;
        s2_hit_next    = (s1_x1_reg > s1_x0_reg) && (s1_y1_reg > s1_y0_reg);
        s2_dx_next     = COORD_BITS'(s1_x1_reg - s1_x0_reg);
        s2_dy_next     = COORD_BITS'(s1_y1_reg - s1_y0_reg);
        s2_area_a_next = s1_area_a_reg;
        s2_area_b_next = s1_area_b_reg;
    end

    always_comb
    begin
        s3_valid_next = s2_valid_reg;
        s3_hit_next   = s2_hit_reg;
        s3_ovl_next   = s2_hit_reg ? AREA_BITS'(s2_dx_reg) * AREA_BITS'(s2_dy_reg) : '0;
        s3_sum_next   = UNION_BITS'(s2_area_a_reg) + UNION_BITS'(s2_area_b_reg);
    end

    always_comb
    begin
        s4_valid_next             = s3_valid_reg;
        s4_item_next.hit          = s3_hit_reg;
        s4_item_next.overlap_area = s3_ovl_reg;
        s4_item_next.union_size   = s3_sum_reg - UNION_BITS'(s3_ovl_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_area_a_reg <= s1_area_a_next;
            s1_area_b_reg <= s1_area_b_next;
            s1_x0_reg     <= s1_x0_next;
            s1_y0_reg     <= s1_y0_next;
            s1_x1_reg     <= s1_x1_next;
            s1_y1_reg     <= s1_y1_next;
            s2_hit_reg    <= s2_hit_next;
            s2_dx_reg     <= s2_dx_next;
            s2_dy_reg     <= s2_dy_next;
            s2_area_a_reg <= s2_area_a_next;
            s2_area_b_reg <= s2_area_b_next;
            s3_hit_reg    <= s3_hit_next;
            s3_ovl_reg    <= s3_ovl_next;
            s3_sum_reg    <= s3_sum_next;
            s4_item_reg   <= s4_item_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_item  = s4_item_reg;

endmodule

`default_nettype wire

[src/bioiu_div.sv]
// Pipelined restoring divider that produces one ratio bit per stage.
`timescale 1ns / 1ps
`default_nettype none
`include "box_intersection_over_union_unit_defines.svh"

module bioiu_div
    import bioiu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  geom_item_t  in_item,
    output logic        out_valid,
    output iou_result_t out_result
);

    localparam int STEPS = RATIO_BITS;

    logic                  valid_reg [STEPS];
    logic [UNION_BITS-1:0] rem_reg   [STEPS];
    logic [RATIO_BITS-1:0] quot_reg  [STEPS];
    geom_item_t            item_reg  [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            logic                  valid_in;
            logic [UNION_BITS-1:0] rem_in;
            logic [RATIO_BITS-1:0] quot_in;
            geom_item_t            item_in;
            logic [UNION_BITS:0]   trial;
            logic                  fits;
            logic [UNION_BITS-1:0] rem_next;
            logic [RATIO_BITS-1:0] quot_next;

            if (k == 0)
            begin : g_first
                assign valid_in = in_valid;
                assign rem_in   = UNION_BITS'(in_item.overlap_area);
                assign quot_in  = '0;
                assign item_in  = in_item;
                assign trial    = {1'b0, rem_in};
            end
            else
            begin : g_rest
                assign valid_in = valid_reg[k-1];
                assign rem_in   = rem_reg[k-1];
                assign quot_in  = quot_reg[k-1];
                assign item_in  = item_reg[k-1];
                assign trial    = {rem_in, 1'b0};
            end

            always_comb
            begin
                fits      = trial >= {1'b0, item_in.union_size};
                rem_next  = fits ? UNION_BITS'(trial - {1'b0, item_in.union_size})
                                 : UNION_BITS'(trial);
                quot_next = {quot_in[RATIO_BITS-2:0], fits};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    quot_reg[k] <= quot_next;
                    item_reg[k] <= item_in;
                end
            end
        end
    endgenerate

    assign out_valid                = valid_reg[STEPS-1];
    assign out_result.overlap_ratio = item_reg[STEPS-1].hit ? quot_reg[STEPS-1] : '0;
    assign out_result.overlap_area  = item_reg[STEPS-1].overlap_area;
    assign out_result.union_size    = item_reg[STEPS-1].union_size;

    // A real overlap never yields a ratio above one.
    `BIOIU_ASSERT_IMPLY(a_ratio_at_most_one, clk, rst_n,
        valid_reg[STEPS-1] && item_reg[STEPS-1].hit, quot_reg[STEPS-1] <= RATIO_ONE)

endmodule

`default_nettype wire

[src/bioiu_out.sv]
// Output register with a skid entry that decouples the pipeline from the result stall.
`timescale 1ns / 1ps
`default_nettype none
`include "box_intersection_over_union_unit_defines.svh"

module bioiu_out
    import bioiu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pipe_valid,
    input  iou_result_t pipe_result,
    output logic        en,
    output logic        iou_valid,
    input  logic        iou_stall,
    output iou_result_t iou
);

    logic        out_valid_reg, out_valid_next;
    iou_result_t out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    iou_result_t skid_reg, skid_next;
    logic        take;
    logic        fire;

    always_comb
    begin
        en              = !skid_valid_reg;
        take            = pipe_valid && en;
        fire            = out_valid_reg && !iou_stall;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = take;
                out_next       = pipe_result;
            end
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
            skid_next       = pipe_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign iou_valid = out_valid_reg;
    assign iou       = out_reg;

    // The skid entry only fills behind a held result, and drains ahead of new work.
    `BIOIU_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `BIOIU_ASSERT_NEXT(a_stalled_take_to_skid, clk, rst_n,
        out_valid_reg && iou_stall && take, skid_valid_reg)
    `BIOIU_ASSERT_NEXT(a_skid_drains, clk, rst_n,
        skid_valid_reg && !iou_stall, out_valid_reg && !skid_valid_reg)

endmodule

`default_nettype wire

[src/box_intersection_over_union_unit.sv]
// An accepted request passes the geometry stages, the divider stages and the output register before iou_valid.
// Throughput: one box pair per cycle while box_stall is low; the divider resolves one ratio bit per stage.
// Stages: four geometry stages, seventeen divider stages and one output register.
// Reset clears only the valid bits; the datapath registers are left unreset.
// Top level of the box intersection over union unit.
`timescale 1ns / 1ps
`default_nettype none

module box_intersection_over_union_unit
    import bioiu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        box_valid,
    output logic        box_stall,
    input  box_pair_t   box,
    output logic        iou_valid,
    input  logic        iou_stall,
    output iou_result_t iou
);

    logic        en;
    logic        geom_valid;
    geom_item_t  geom_item;
    logic        div_valid;
    iou_result_t div_result;

    assign box_stall = !en;

    bioiu_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (box_valid),
        .in_box    (box),
        .out_valid (geom_valid),
        .out_item  (geom_item)
    );

    bioiu_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (geom_valid),
        .in_item    (geom_item),
        .out_valid  (div_valid),
        .out_result (div_result)
    );

    bioiu_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .pipe_valid  (div_valid),
        .pipe_result (div_result),
        .en          (en),
        .iou_valid   (iou_valid),
        .iou_stall   (iou_stall),
        .iou         (iou)
    );

endmodule

`default_nettype wire
